FILE: hdl/pca_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Shared types and constants for the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pca_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_GAIN_P      = 3'd0;
   localparam logic [2:0] CSR_GAIN_I      = 3'd1;
   localparam logic [2:0] CSR_GAIN_D      = 3'd2;
   localparam logic [2:0] CSR_INTEG_LIMIT = 3'd3;
   localparam logic [2:0] CSR_DRIVE_LIMIT = 3'd4;

   // Datapath widths
   localparam int VAL_W     = 32;
   localparam int LIM_W     = 31;
   localparam int STEP_W    = 24;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int FRAC_W    = 16;
   localparam int TERM_W    = PROD_W - FRAC_W;
   localparam int ACC_W     = 52;
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = STEP_W;
   localparam int DIV_CNT_W = 6;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_ET,
      ST_ACC_ET,
      ST_ACC_P,
      ST_ACC_I,
      ST_WAIT_DIV,
      ST_MUL_D,
      ST_ACC_D,
      ST_FINISH
   } state_type;

   // Divider control and status
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
   } div_sts_type;

endpackage

FILE: hdl/pca_mul.sv
// ----------------------------------------------------------------------------
// PID controller multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pca_mul (
   input  logic                                 clock,
   input  logic signed [pca_pkg::MUL_W-1:0]     op_a,
   input  logic signed [pca_pkg::MUL_W-1:0]     op_b,
   output logic signed [pca_pkg::PROD_W-1:0]    product
);
   import pca_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   // One product per cycle, available the cycle after the operands.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;

endmodule

FILE: hdl/pca_div.sv
// ----------------------------------------------------------------------------
// PID controller divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pca_div (
   input  logic                              clock,
   input  logic                              reset,
   input  pca_pkg::div_ctl_type              ctl,
   input  logic [pca_pkg::DIV_NUM_W-1:0]     numerator,
   input  logic [pca_pkg::DIV_DEN_W-1:0]     denominator,
   output pca_pkg::div_sts_type              sts,
   output logic [pca_pkg::DIV_NUM_W-1:0]     quotient
);
   import pca_pkg::*;

   logic                   busy_ff;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [DIV_NUM_W-1:0]   quot_ff;
   logic [DIV_DEN_W-1:0]   rem_ff;
   logic [DIV_DEN_W-1:0]   den_ff;
   logic [DIV_DEN_W:0]     rem_shift;
   logic [DIV_DEN_W:0]     rem_diff;
   logic                   fits;

   // Bring down the next numerator bit and try a subtract.
   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIV_NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};
   end

   // Control: busy until all quotient bits have been formed.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath: numerator shifts out as the quotient shifts in.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         quot_ff <= numerator;
         rem_ff  <= '0;
         den_ff  <= denominator;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[DIV_NUM_W-2:0], fits};
         rem_ff  <= fits ? rem_diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
      end
   end

   assign sts.busy = busy_ff;
   assign quotient = quot_ff;

endmodule

FILE: hdl/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// PID controller with anti-windup
// Q16.16 PID controller with conditional integration and output clamping.
// ----------------------------------------------------------------------------
// Usage: a request carries setpoint, measurement, step time (Q8.16 seconds)
// and feedforward on the req_ channel (valid/ready). Each request yields one
// drive value on the rsp_ channel (valid/ready). Gains and limits are written
// through the csr_ port; the user must write them only while the block is
// idle, which the block itself does not enforce. Writing a gain clears the
// integral, the stored error and the first-request flag.
// Sequence: a request is worked on by four passes through the one shared
// 33x33 multiplier and, when the derivative is computed, a wait for the
// 48-step bit-serial divider that forms it. One request is in work at a time;
// req_ready is high only while the sequencer is idle, so a new request is
// accepted only once the previous one has left its final step. On the first
// request or with a zero step time the divider is not started.
// The result sits in an output register. If the receiver stalls, the next
// request can still be accepted and worked on; it waits in its final step
// until the previous result has been taken.
// Reset (synchronous, active high) clears gains, limits and state to zero.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pca_pkg::VAL_W-1:0]     req_setpoint,
   input  logic signed [pca_pkg::VAL_W-1:0]     req_measured,
   input  logic [pca_pkg::STEP_W-1:0]           req_step_time,
   input  logic signed [pca_pkg::VAL_W-1:0]     req_feedforward_term,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pca_pkg::VAL_W-1:0]     rsp_drive,
   // Configuration port
   input  logic                                 csr_we,
   input  logic [2:0]                           csr_index,
   input  logic [pca_pkg::VAL_W-1:0]            csr_wdata
);
   import pca_pkg::*;

   localparam logic signed [VAL_W-1:0] S32_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] S32_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [DIV_NUM_W-1:0]    NEG_LIMIT = DIV_NUM_W'(64'h8000_0000);

   // Configuration registers
   logic signed [VAL_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [LIM_W-1:0]        integ_lim_ff, drive_lim_ff;

   // Sequencer and datapath registers
   state_type               state_ff, state_in;
   logic signed [VAL_W-1:0] sp_ff, meas_ff, fwd_ff;
   logic [STEP_W-1:0]       dt_ff;
   logic signed [VAL_W-1:0] err_ff, err_in;
   logic signed [VAL_W-1:0] cand_ff, cand_in;
   logic signed [VAL_W-1:0] deriv_ff, deriv_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] integral_ff, integral_in;
   logic signed [VAL_W-1:0] last_err_ff, last_err_in;
   logic                    primed_ff, primed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] drive_ff, drive_in;

   // Shared units
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] product;
   logic signed [ACC_W-1:0]  term;
   div_ctl_type              div_ctl;
   div_sts_type              div_sts;
   logic [DIV_NUM_W-1:0]     div_num;
   logic [DIV_NUM_W-1:0]     quot;

   // Combinational helpers
   logic signed [VAL_W:0]   err_diff;
   logic signed [VAL_W:0]   der_diff;
   logic [VAL_W:0]          der_mag;
   logic signed [ACC_W-1:0] cand_sum;
   logic signed [ACC_W-1:0] ilim_w, dlim_w;
   logic                    err_pos, err_neg, further, gain_write, out_free;

   pca_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   pca_div u_div (
      .clock       (clock),
      .reset       (reset),
      .ctl         (div_ctl),
      .numerator   (div_num),
      .denominator (dt_ff),
      .sts         (div_sts),
      .quotient    (quot)
   );

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         integ_lim_ff <= '0;
         drive_lim_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_P:      gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:      gain_i_ff    <= csr_wdata;
            CSR_GAIN_D:      gain_d_ff    <= csr_wdata;
            CSR_INTEG_LIMIT: integ_lim_ff <= csr_wdata[LIM_W-1:0];
            CSR_DRIVE_LIMIT: drive_lim_ff <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign gain_write = csr_we && (csr_index == CSR_GAIN_P || csr_index == CSR_GAIN_I ||
                                  csr_index == CSR_GAIN_D);

   // Arithmetic shared by several steps.
   always_comb begin
      err_diff = {sp_ff[VAL_W-1], sp_ff} - {meas_ff[VAL_W-1], meas_ff};
      der_diff = {err_ff[VAL_W-1], err_ff} - {last_err_ff[VAL_W-1], last_err_ff};
      der_mag  = der_diff[VAL_W] ? -der_diff : der_diff;
      div_num  = {der_mag[VAL_W-1:0], {FRAC_W{1'b0}}};
      // Product scaled down by 2^16, rounded toward minus infinity.
      term     = ACC_W'($signed(product[PROD_W-1:FRAC_W]));
      cand_sum = ACC_W'(integral_ff) + term;
      ilim_w   = ACC_W'({1'b0, integ_lim_ff});
      dlim_w   = ACC_W'({1'b0, drive_lim_ff});
      err_pos  = !err_ff[VAL_W-1] && (err_ff != '0);
      err_neg  = err_ff[VAL_W-1];
      further  = (acc_ff > dlim_w && err_pos) || (acc_ff < -dlim_w && err_neg);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, unit operands and datapath updates.
   always_comb begin
      state_in       = state_ff;
      err_in         = err_ff;
      cand_in        = cand_ff;
      deriv_in       = deriv_ff;
      acc_in         = acc_ff;
      neg_in         = neg_ff;
      integral_in    = integral_ff;
      last_err_in    = last_err_ff;
      primed_in      = primed_ff;
      drive_in       = drive_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      mul_a          = '0;
      mul_b          = '0;
      div_ctl.start  = 1'b0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            // Error, saturated to 32 bits.
            if (err_diff[VAL_W] != err_diff[VAL_W-1]) begin
               err_in = err_diff[VAL_W] ? S32_MIN : S32_MAX;
            end else begin
               err_in = err_diff[VAL_W-1:0];
            end
            state_in = ST_MUL_ET;
         end
         ST_MUL_ET: begin
            // Error times step; derivative divide runs alongside.
            mul_a    = {err_ff[VAL_W-1], err_ff};
            mul_b    = MUL_W'({1'b0, dt_ff});
            neg_in   = der_diff[VAL_W];
            deriv_in = '0;
            div_ctl.start = primed_ff && (dt_ff != '0);
            state_in = ST_ACC_ET;
         end
         ST_ACC_ET: begin
            // Integral candidate, clamped to the integral limit.
            if (cand_sum > ilim_w) begin
               cand_in = ilim_w[VAL_W-1:0];
            end else if (cand_sum < -ilim_w) begin
               cand_in = VAL_W'(-ilim_w);
            end else begin
               cand_in = cand_sum[VAL_W-1:0];
            end
            mul_a    = {gain_p_ff[VAL_W-1], gain_p_ff};
            mul_b    = {err_ff[VAL_W-1], err_ff};
            state_in = ST_ACC_P;
         end
         ST_ACC_P: begin
            acc_in   = ACC_W'(fwd_ff) + term;
            mul_a    = {gain_i_ff[VAL_W-1], gain_i_ff};
            mul_b    = {cand_ff[VAL_W-1], cand_ff};
            state_in = ST_ACC_I;
         end
         ST_ACC_I: begin
            acc_in   = acc_ff + term;
            state_in = ST_WAIT_DIV;
         end
         ST_WAIT_DIV: begin
            // Derivative from the divider, saturated to 32 bits.
            if (!div_sts.busy) begin
               if (primed_ff && (dt_ff != '0)) begin
                  if (neg_ff) begin
                     deriv_in = (quot > NEG_LIMIT) ? S32_MIN : VAL_W'(-quot[VAL_W-1:0]);
                  end else begin
                     deriv_in = (quot > NEG_LIMIT - 1'b1) ? S32_MAX : quot[VAL_W-1:0];
                  end
               end
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            mul_a    = {gain_d_ff[VAL_W-1], gain_d_ff};
            mul_b    = {deriv_ff[VAL_W-1], deriv_ff};
            state_in = ST_ACC_D;
         end
         ST_ACC_D: begin
            acc_in   = acc_ff + term;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Clamp the output and update state once the output register is free.
            if (out_free) begin
               if (acc_ff > dlim_w) begin
                  drive_in = dlim_w[VAL_W-1:0];
               end else if (acc_ff < -dlim_w) begin
                  drive_in = VAL_W'(-dlim_w);
               end else begin
                  drive_in = acc_ff[VAL_W-1:0];
               end
               if (!further) begin
                  integral_in = cand_ff;
               end
               last_err_in  = err_ff;
               primed_in    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A gain write clears the controller state.
      if (gain_write) begin
         integral_in = '0;
         last_err_in = '0;
         primed_in   = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff  <= '0;
         last_err_ff  <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integral_ff  <= integral_in;
         last_err_ff  <= last_err_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sp_ff   <= req_setpoint;
         meas_ff <= req_measured;
         dt_ff   <= req_step_time;
         fwd_ff  <= req_feedforward_term;
      end
      err_ff   <= err_in;
      cand_ff  <= cand_in;
      deriv_ff <= deriv_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      drive_ff <= drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

   // An accepted request starts the sequence at the error step.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_ERR))
      else $error("accepted request did not start the sequence");

   // The divider is always finished while the block is idle.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_sts.busy)
      else $error("divider busy while idle");

   // A pending result is never overwritten by the next one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FINISH))
      else $error("finished request left while the output was stalled");

endmodule

FILE: bench/pca_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller drive checker
// Watches the request, result and register ports of the PID controller. It
// keeps its own copy of gains, limits and loop state, and works out the drive
// for every accepted request. Each accepted result is compared against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pca_drive_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [pca_pkg::VAL_W-1:0]    req_setpoint,
   input  logic signed [pca_pkg::VAL_W-1:0]    req_measured,
   input  logic [pca_pkg::STEP_W-1:0]          req_step_time,
   input  logic signed [pca_pkg::VAL_W-1:0]    req_feedforward_term,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [pca_pkg::VAL_W-1:0]    rsp_drive,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [pca_pkg::VAL_W-1:0]           csr_wdata,
   output int                                  fail_count,
   output int                                  outstanding
);
   import pca_pkg::*;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam int     PRINT_CAP = 100;

   // Mirrored registers and loop state.
   logic signed [VAL_W-1:0] gain_p_q;
   logic signed [VAL_W-1:0] gain_i_q;
   logic signed [VAL_W-1:0] gain_d_q;
   logic [LIM_W-1:0]        integ_limit_q;
   logic [LIM_W-1:0]        drive_limit_q;
   logic signed [VAL_W-1:0] integral_q;
   logic signed [VAL_W-1:0] last_err_q;
   logic                    primed_q;

   // Predicted drive values, oldest first.
   logic signed [VAL_W-1:0] expected_drive_q[$];
   int                      mismatch_total = 0;

   assign fail_count = mismatch_total;

   task automatic report_mismatch(input string what);
      if (mismatch_total < PRINT_CAP) begin
         $display("ERROR at %0t ns: %s", $time, what);
      end
      mismatch_total++;
   endtask

   function automatic longint sat_s32(input longint v);
      if (v > S32_MAX) begin
         return S32_MAX;
      end
      if (v < S32_MIN) begin
         return S32_MIN;
      end
      return v;
   endfunction

   function automatic longint clamp_sym(input longint v, input longint lim);
      if (v > lim) begin
         return lim;
      end
      if (v < -lim) begin
         return -lim;
      end
      return v;
   endfunction

   function automatic void clear_loop_state();
      integral_q = '0;
      last_err_q = '0;
      primed_q   = 1'b0;
   endfunction

   // Register write as the block sees it; a gain write restarts the loop.
   function automatic void write_register(input logic [2:0] idx,
                                          input logic [VAL_W-1:0] data);
      case (idx)
         CSR_GAIN_P: begin
            gain_p_q = data;
            clear_loop_state();
         end
         CSR_GAIN_I: begin
            gain_i_q = data;
            clear_loop_state();
         end
         CSR_GAIN_D: begin
            gain_d_q = data;
            clear_loop_state();
         end
         CSR_INTEG_LIMIT: integ_limit_q = data[LIM_W-1:0];
         CSR_DRIVE_LIMIT: drive_limit_q = data[LIM_W-1:0];
         default: ;
      endcase
   endfunction

   // One controller update. Gain products are floored after the 16 bit
   // shift, which an arithmetic shift of the exact product gives directly.
   function automatic logic signed [VAL_W-1:0] predict_drive(
      input logic signed [VAL_W-1:0] sp,
      input logic signed [VAL_W-1:0] meas,
      input logic [STEP_W-1:0]       dt,
      input logic signed [VAL_W-1:0] ff);
      longint err;
      longint dt_l;
      longint deriv;
      longint cand;
      longint unsat;
      longint lim;
      longint drv;
      bit     further;
      err   = sat_s32(longint'(sp) - longint'(meas));
      dt_l  = longint'(dt);
      lim   = longint'(drive_limit_q);
      deriv = 0;
      if (primed_q && dt_l != 0) begin
         deriv = sat_s32(((err - longint'(last_err_q)) * 65536) / dt_l);
      end
      cand = clamp_sym(longint'(integral_q) + ((err * dt_l) >>> 16),
                       longint'(integ_limit_q));
      unsat = longint'(ff)
            + ((longint'(gain_p_q) * err) >>> 16)
            + ((longint'(gain_i_q) * cand) >>> 16)
            + ((longint'(gain_d_q) * deriv) >>> 16);
      drv = clamp_sym(unsat, lim);
      // Conditional integration: hold the integral while pushing further
      // into saturation.
      further = (unsat > lim && err > 0) || (unsat < -lim && err < 0);
      if (!further) begin
         integral_q = cand[VAL_W-1:0];
      end
      last_err_q = err[VAL_W-1:0];
      primed_q   = 1'b1;
      return drv[VAL_W-1:0];
   endfunction

   // Results are retired before the request of the same edge is predicted.
   always @(posedge clock) begin : monitor
      logic signed [VAL_W-1:0] want;
      if (reset) begin
         gain_p_q      = '0;
         gain_i_q      = '0;
         gain_d_q      = '0;
         integ_limit_q = '0;
         drive_limit_q = '0;
         clear_loop_state();
         expected_drive_q.delete();
      end else begin
         if (csr_we) begin
            write_register(csr_index, csr_wdata);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_drive_q.size() == 0) begin
               report_mismatch($sformatf("drive %h with no request outstanding",
                                         rsp_drive));
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_drive !== want) begin
                  report_mismatch($sformatf("drive expected %h, got %h",
                                            want, rsp_drive));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_drive_q.push_back(predict_drive(req_setpoint, req_measured,
                                                     req_step_time,
                                                     req_feedforward_term));
         end
      end
      outstanding <= expected_drive_q.size();
   end

endmodule

FILE: bench/tb_pid_controller_antiwindup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives requests and register writes into the PID controller with random
// idle cycles on both channels. A directed pass covers field extremes, zero
// limits, zero step time and the first request after a gain write; random
// settings and requests follow. The drive checker predicts every result.
// ----------------------------------------------------------------------------
module tb_pid_controller_antiwindup;
   import pca_pkg::*;

   localparam int ITEMS_PER_SETTING = 54;
   localparam int SETTINGS_PER_PHASE = 8;
   localparam int DRAIN_GUARD = 200000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_setpoint = '0;
   logic signed [VAL_W-1:0] req_measured = '0;
   logic [STEP_W-1:0]       req_step_time = '0;
   logic signed [VAL_W-1:0] req_feedforward_term = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_drive;
   logic                    csr_we = 1'b0;
   logic [2:0]              csr_index = '0;
   logic [VAL_W-1:0]        csr_wdata = '0;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Loose model of the process being regulated.
   logic signed [VAL_W-1:0] plant = '0;
   logic signed [VAL_W-1:0] target = '0;

   pid_controller_antiwindup dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_setpoint         (req_setpoint),
      .req_measured         (req_measured),
      .req_step_time        (req_step_time),
      .req_feedforward_term (req_feedforward_term),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_drive            (rsp_drive),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   pca_drive_checker drive_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_setpoint         (req_setpoint),
      .req_measured         (req_measured),
      .req_step_time        (req_step_time),
      .req_feedforward_term (req_feedforward_term),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_drive            (rsp_drive),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Hard stop in case the block hangs.
   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   // Offer one request, after a random idle gap, and hold it until accepted.
   task automatic send_request(input logic signed [VAL_W-1:0] sp,
                               input logic signed [VAL_W-1:0] meas,
                               input logic [STEP_W-1:0]       dt,
                               input logic signed [VAL_W-1:0] ff);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_setpoint         <= sp;
      req_measured         <= meas;
      req_step_time        <= dt;
      req_feedforward_term <= ff;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Stop offering requests and wait until every drive has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      for (int n = 0; n < DRAIN_GUARD && outstanding != 0; n++) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [VAL_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] pick_gain();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(7))
         0: v = '0;
         1: v = 32'h7FFF_FFFF;
         2: v = 32'h8000_0000;
         3: v = $urandom;
         default: begin
            // Within plus or minus 4.0.
            v = $urandom_range(0, 32'h0008_0000);
            v = v - 32'sh0004_0000;
         end
      endcase
      return v;
   endfunction

   function automatic logic [VAL_W-1:0] pick_limit();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1, 32'h0020_0000);
      endcase
   endfunction

   // New gains and limits; with a partial write, limits may change alone.
   task automatic load_random_setting(input bit every);
      logic signed [VAL_W-1:0] offset;
      if (every || $urandom_range(1)) write_csr(CSR_GAIN_P, pick_gain());
      if (every || $urandom_range(1)) write_csr(CSR_GAIN_I, pick_gain());
      if (every || $urandom_range(1)) write_csr(CSR_GAIN_D, pick_gain());
      if (every || $urandom_range(1)) write_csr(CSR_INTEG_LIMIT, pick_limit());
      if (every || $urandom_range(1)) write_csr(CSR_DRIVE_LIMIT, pick_limit());
      if ($urandom_range(7) == 0) begin
         write_csr(3'($urandom_range(5, 7)), $urandom);
      end
      target = $urandom_range(0, 32'h00C8_0000);
      target = target - 32'sh0064_0000;
      offset = $urandom_range(0, 32'h0014_0000);
      plant  = target + offset - 32'sh000A_0000;
   endtask

   // Mostly a tracking loop with a drifting measurement; some pure noise.
   task automatic send_random_request();
      logic signed [VAL_W-1:0] sp;
      logic signed [VAL_W-1:0] meas;
      logic signed [VAL_W-1:0] ff;
      logic signed [VAL_W-1:0] drift;
      logic [STEP_W-1:0]       dt;
      if ($urandom_range(99) < 25) begin
         sp   = $urandom;
         meas = $urandom;
         dt   = STEP_W'($urandom);
         ff   = $urandom;
      end else begin
         if ($urandom_range(19) == 0) begin
            target = $urandom_range(0, 32'h00C8_0000);
            target = target - 32'sh0064_0000;
         end
         drift = $urandom_range(0, 32'h0000_4000);
         plant = plant + drift - 32'sh0000_2000;
         sp    = target;
         meas  = plant;
         case ($urandom_range(9))
            0: dt = '0;
            1: dt = 24'hFF_FFFF;
            2: dt = STEP_W'($urandom);
            default: dt = STEP_W'($urandom_range(1, 6554));
         endcase
         ff = $urandom_range(0, 32'h0002_0000);
         ff = ff - 32'sh0001_0000;
      end
      send_request(sp, meas, dt, ff);
   endtask

   // Stimulus and verdict.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: both limits zero, so every drive is zero.
      send_request(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0000, 32'h8000_0000);
      drain_results();

      // Moderate gains with open limits; unknown indexes must be ignored.
      write_csr(3'd5, 32'hFFFF_FFFF);
      write_csr(3'd6, 32'h1234_5678);
      write_csr(3'd7, 32'h0001_0000);
      write_csr(CSR_GAIN_P, 32'h0001_0000);
      write_csr(CSR_GAIN_I, 32'h0000_8000);
      write_csr(CSR_GAIN_D, 32'h0000_4000);
      write_csr(CSR_INTEG_LIMIT, 32'h7FFF_FFFF);
      write_csr(CSR_DRIVE_LIMIT, 32'hFFFF_FFFF);
      // The first request after a gain write has no derivative term.
      send_request(32'h0005_0000, 32'h0001_0000, 24'h00_0666, 32'h0000_0000);
      send_request(32'h0005_0000, 32'h0002_0000, 24'h00_0666, 32'h0000_1000);
      // Zero step time: no derivative and nothing integrated.
      send_request(32'h0005_0000, 32'h0003_0000, 24'h00_0000, 32'h0000_0000);
      // The error saturates in both directions.
      send_request(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 32'h8000_0000);
      send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h00_0001, 32'h0000_0000);
      send_request(32'h8000_0000, 32'h0000_0000, 24'h00_0001, 32'hFFFF_FFFF);
      drain_results();

      // Extreme gains against tight limits: the output saturates and the
      // integral must hold while the error pushes further.
      write_csr(CSR_GAIN_P, 32'h7FFF_FFFF);
      write_csr(CSR_GAIN_I, 32'h8000_0000);
      write_csr(CSR_GAIN_D, 32'h8000_0000);
      write_csr(CSR_INTEG_LIMIT, 32'h0001_0000);
      write_csr(CSR_DRIVE_LIMIT, 32'h0002_0000);
      repeat (3) send_request(32'h0010_0000, 32'h0000_0000, 24'h01_0000, 32'h0);
      repeat (2) send_request(32'h0000_0000, 32'h0010_0000, 24'h01_0000, 32'h0);
      send_request(32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 32'h0000_0000);
      drain_results();

      // A limit write keeps the loop state; zero integrator limit.
      write_csr(CSR_INTEG_LIMIT, 32'h0000_0000);
      write_csr(CSR_DRIVE_LIMIT, 32'h7FFF_FFFF);
      send_request(32'h0003_0000, 32'h0001_0000, 24'h00_8000, 32'h0000_0000);
      send_request(32'hFFFD_0000, 32'h0001_0000, 24'h00_8000, 32'h0000_0000);
      drain_results();

      // Zero drive limit with an open integrator.
      write_csr(CSR_INTEG_LIMIT, 32'h7FFF_FFFF);
      write_csr(CSR_DRIVE_LIMIT, 32'h0000_0000);
      send_request(32'h0003_0000, 32'h0001_0000, 24'h00_8000, 32'h7FFF_FFFF);
      send_request(32'hFFFD_0000, 32'h0001_0000, 24'h00_8000, 32'h8000_0000);
      drain_results();

      // Random settings, under three idling patterns.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 21;
               recv_idle_pct <= 48;
            end
            1: begin
               send_idle_pct <= 48;
               recv_idle_pct <= 21;
            end
            default: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
            load_random_setting(s == 0);
            repeat (ITEMS_PER_SETTING) send_random_request();
            drain_results();
         end
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
